// ===== hw/rtl/wfs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfs_pkg
// Types, constants and weight tables shared by the wall-follow steering unit.
// ----------------------------------------------------------------------------
package wfs_pkg;

  localparam int NUM_LANES  = 8;
  localparam int LANE_IDX_W = 3;
  localparam int SENSOR_W   = 13;
  localparam int THRESH_W   = 12;
  localparam int SPEED_CFG_W = 10;
  localparam int SPEED_W    = 11;
  localparam int ADJ_W      = 14;  // reading less the largest wall offset
  localparam int READING_SHIFT = 4;
  localparam int SHIFT_W    = ADJ_W - READING_SHIFT;
  localparam int WEIGHT_W   = 5;
  localparam int PROD_W     = 13;
  localparam int SUM_W      = 17;
  localparam int OFFSET_W   = 10;

  localparam logic [OFFSET_W-1:0] WALL_OFFSET_SIDE  = 10'd600;
  localparam logic [OFFSET_W-1:0] WALL_OFFSET_FRONT = 10'd200;
  localparam logic [OFFSET_W-1:0] WALL_OFFSET_BACK  = 10'd100;

  // Configuration register indexes (word address bits [4:2]).
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_SIDE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd4;

  localparam logic                   FOLLOW_SIDE_RST    = 1'b1;
  localparam logic [THRESH_W-1:0]    NEAR_THRESHOLD_RST = 12'd50;
  localparam logic [THRESH_W-1:0]    WALL_THRESHOLD_RST = 12'd300;
  localparam logic [SPEED_CFG_W-1:0] BIAS_SPEED_RST     = 10'd350;
  localparam logic [SPEED_CFG_W-1:0] MAX_SPEED_RST      = 10'd800;

  // Lane result handed from the lanes to the merging stage.
  typedef struct packed {
    logic                     above;
    logic signed [PROD_W-1:0] product;
  } lane_res_t;

  // Left wheel weight of one sensor; the right wheel uses the negated value.
  function automatic logic signed [WEIGHT_W-1:0] lane_weight(
    input logic                  follow_right,
    input logic [LANE_IDX_W-1:0] idx
  );
    logic signed [WEIGHT_W-1:0] w;
    unique case (idx)
      3'd0:    w = follow_right ? -5'sd10 : 5'sd10;
      3'd1:    w = -5'sd10;
      3'd2:    w = -5'sd5;
      3'd3:    w = 5'sd0;
      3'd4:    w = 5'sd0;
      3'd5:    w = 5'sd5;
      3'd6:    w = 5'sd10;
      3'd7:    w = follow_right ? -5'sd10 : 5'sd10;
      default: w = 5'sd0;
    endcase
    return w;
  endfunction

  // Offset taken off a reading when the side sensor sees a wall.
  function automatic logic [OFFSET_W-1:0] lane_offset(
    input logic                  follow_right,
    input logic [LANE_IDX_W-1:0] idx
  );
    logic [OFFSET_W-1:0] o;
    o = '0;
    if (follow_right) begin
      unique case (idx)
        3'd1:    o = WALL_OFFSET_FRONT;
        3'd2:    o = WALL_OFFSET_SIDE;
        3'd3:    o = WALL_OFFSET_BACK;
        default: o = '0;
      endcase
    end else begin
      unique case (idx)
        3'd4:    o = WALL_OFFSET_BACK;
        3'd5:    o = WALL_OFFSET_SIDE;
        3'd6:    o = WALL_OFFSET_FRONT;
        default: o = '0;
      endcase
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/wfs_scan_if.sv =====
// ----------------------------------------------------------------------------
// wfs_scan_if
// Valid/ready channel carrying one scan of eight proximity readings.
// ----------------------------------------------------------------------------
interface wfs_scan_if;
  import wfs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SENSOR_W-1:0] sensor_0;
  logic signed [SENSOR_W-1:0] sensor_1;
  logic signed [SENSOR_W-1:0] sensor_2;
  logic signed [SENSOR_W-1:0] sensor_3;
  logic signed [SENSOR_W-1:0] sensor_4;
  logic signed [SENSOR_W-1:0] sensor_5;
  logic signed [SENSOR_W-1:0] sensor_6;
  logic signed [SENSOR_W-1:0] sensor_7;

  modport source (
    output valid, sensor_0, sensor_1, sensor_2, sensor_3,
           sensor_4, sensor_5, sensor_6, sensor_7,
    input  ready
  );
  modport sink (
    input  valid, sensor_0, sensor_1, sensor_2, sensor_3,
           sensor_4, sensor_5, sensor_6, sensor_7,
    output ready
  );
endinterface

// ===== hw/rtl/wfs_speed_if.sv =====
// ----------------------------------------------------------------------------
// wfs_speed_if
// Valid/ready channel carrying one pair of wheel speeds and the straight flag.
// ----------------------------------------------------------------------------
interface wfs_speed_if;
  import wfs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic                      went_straight;

  modport source (
    output valid, left_speed, right_speed, went_straight,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, went_straight,
    output ready
  );
endinterface

// ===== hw/rtl/wfs_lane.sv =====
// ----------------------------------------------------------------------------
// wfs_lane
// One sensor lane: wall offset, floor shift, weighting and threshold test.
// ----------------------------------------------------------------------------
module wfs_lane
  import wfs_pkg::*;
(
  input  logic signed [SENSOR_W-1:0] reading_i,
  input  logic        [OFFSET_W-1:0] offset_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  input  logic        [THRESH_W-1:0] near_threshold_i,
  output lane_res_t                  res_o
);

  logic signed [ADJ_W-1:0]          adj;
  logic signed [ADJ_W-1:0]          adj_shr;
  logic signed [SHIFT_W-1:0]        scaled;
  logic signed [SHIFT_W+WEIGHT_W-1:0] prod_full;

  always_comb begin
    adj       = $signed({reading_i[SENSOR_W-1], reading_i})
              - $signed({{(ADJ_W-OFFSET_W){1'b0}}, offset_i});
    // Arithmetic shift rounds towards minus infinity, as required.
    adj_shr   = adj >>> READING_SHIFT;
    scaled    = adj_shr[SHIFT_W-1:0];
    prod_full = scaled * weight_i;
    res_o.product = prod_full[PROD_W-1:0];
    res_o.above   = $signed({reading_i[SENSOR_W-1], reading_i})
                  > $signed({{(ADJ_W-THRESH_W){1'b0}}, near_threshold_i});
  end

endmodule

// ===== hw/rtl/wfs_merge.sv =====
// ----------------------------------------------------------------------------
// wfs_merge
// Merging stage: sums the lane products, adds the bias and saturates both
// wheel speeds.
// ----------------------------------------------------------------------------
module wfs_merge
  import wfs_pkg::*;
(
  input  lane_res_t                     lanes_i [NUM_LANES],
  input  logic                          straight_i,
  input  logic        [SPEED_CFG_W-1:0] bias_speed_i,
  input  logic        [SPEED_CFG_W-1:0] max_speed_i,
  output logic signed [SPEED_W-1:0]     left_speed_o,
  output logic signed [SPEED_W-1:0]     right_speed_o
);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] bias_ext;
  logic signed [SUM_W-1:0] max_pos;
  logic signed [SUM_W-1:0] max_neg;
  logic signed [SUM_W-1:0] left_raw;
  logic signed [SUM_W-1:0] right_raw;
  logic signed [SUM_W-1:0] left_sat;
  logic signed [SUM_W-1:0] right_sat;

  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      sum = sum + SUM_W'(lanes_i[k].product);
    end
    // In the straight case the weighted readings do not count.
    if (straight_i) begin
      sum = '0;
    end
    bias_ext  = $signed({{(SUM_W-SPEED_CFG_W){1'b0}}, bias_speed_i});
    max_pos   = $signed({{(SUM_W-SPEED_CFG_W){1'b0}}, max_speed_i});
    max_neg   = -max_pos;
    left_raw  = bias_ext + sum;
    right_raw = bias_ext - sum;

    if (left_raw > max_pos) begin
      left_sat = max_pos;
    end else if (left_raw < max_neg) begin
      left_sat = max_neg;
    end else begin
      left_sat = left_raw;
    end

    if (right_raw > max_pos) begin
      right_sat = max_pos;
    end else if (right_raw < max_neg) begin
      right_sat = max_neg;
    end else begin
      right_sat = right_raw;
    end

    left_speed_o  = left_sat[SPEED_W-1:0];
    right_speed_o = right_sat[SPEED_W-1:0];
  end

endmodule

// ===== hw/rtl/wall_follow_steering_unit.sv =====
// Pipeline: a scan is held in the lane register, then merged into the output
// register. Throughput: one scan per cycle unless the sink stalls; the eight
// sensor lanes run side by side and the merging stage sums their products
// into registered wheel speeds.
// Reset: asynchronous, active low; clears the pipeline valid flags and loads
// the configuration registers with their reset values.
// ----------------------------------------------------------------------------
// wall_follow_steering_unit
// Wall-following steering: eight proximity readings in, two wheel speeds out.
// ----------------------------------------------------------------------------
module wall_follow_steering_unit
  import wfs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wfs_scan_if.sink              scan_i,
  wfs_speed_if.source           speed_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Configuration registers.
  logic                   follow_side_q;
  logic [THRESH_W-1:0]    near_threshold_q;
  logic [THRESH_W-1:0]    wall_threshold_q;
  logic [SPEED_CFG_W-1:0] bias_speed_q;
  logic [SPEED_CFG_W-1:0] max_speed_q;

  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_side_q    <= FOLLOW_SIDE_RST;
      near_threshold_q <= NEAR_THRESHOLD_RST;
      wall_threshold_q <= WALL_THRESHOLD_RST;
      bias_speed_q     <= BIAS_SPEED_RST;
      max_speed_q      <= MAX_SPEED_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FOLLOW_SIDE:    follow_side_q    <= pwdata[0];
        REG_NEAR_THRESHOLD: near_threshold_q <= pwdata[THRESH_W-1:0];
        REG_WALL_THRESHOLD: wall_threshold_q <= pwdata[THRESH_W-1:0];
        REG_BIAS_SPEED:     bias_speed_q     <= pwdata[SPEED_CFG_W-1:0];
        REG_MAX_SPEED:      max_speed_q      <= pwdata[SPEED_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FOLLOW_SIDE:    prdata = {31'd0, follow_side_q};
      REG_NEAR_THRESHOLD: prdata = {{(32-THRESH_W){1'b0}}, near_threshold_q};
      REG_WALL_THRESHOLD: prdata = {{(32-THRESH_W){1'b0}}, wall_threshold_q};
      REG_BIAS_SPEED:     prdata = {{(32-SPEED_CFG_W){1'b0}}, bias_speed_q};
      REG_MAX_SPEED:      prdata = {{(32-SPEED_CFG_W){1'b0}}, max_speed_q};
      default:            prdata = '0;
    endcase
  end

  // Pipeline control: each stage moves on when the one after it has room.
  logic s1_valid_q;
  logic out_valid_q;
  logic s2_en;
  logic s1_en;

  assign s2_en        = !out_valid_q || speed_o.ready;
  assign s1_en        = !s1_valid_q || s2_en;
  assign scan_i.ready = s1_en;

  // Lanes.
  logic signed [SENSOR_W-1:0] reading [NUM_LANES];
  logic                       wall_hit;
  logic signed [SENSOR_W+1:0] side_ext;
  lane_res_t                  lane_res   [NUM_LANES];
  lane_res_t                  lane_res_q [NUM_LANES];
  logic                       straight;
  logic                       straight_q;

  assign reading[0] = scan_i.sensor_0;
  assign reading[1] = scan_i.sensor_1;
  assign reading[2] = scan_i.sensor_2;
  assign reading[3] = scan_i.sensor_3;
  assign reading[4] = scan_i.sensor_4;
  assign reading[5] = scan_i.sensor_5;
  assign reading[6] = scan_i.sensor_6;
  assign reading[7] = scan_i.sensor_7;

  // The wall test looks at the side sensor before any offset is taken off.
  always_comb begin
    side_ext = follow_side_q ? (SENSOR_W+2)'(reading[2]) : (SENSOR_W+2)'(reading[5]);
    wall_hit = side_ext > $signed({3'b000, wall_threshold_q});
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    wfs_lane u_lane (
      .reading_i        (reading[k]),
      .offset_i         (wall_hit ? lane_offset(follow_side_q, LANE_IDX_W'(k))
                                  : OFFSET_W'(0)),
      .weight_i         (lane_weight(follow_side_q, LANE_IDX_W'(k))),
      .near_threshold_i (near_threshold_q),
      .res_o            (lane_res[k])
    );
  end

  always_comb begin
    straight = 1'b1;
    for (int k = 0; k < NUM_LANES; k++) begin
      straight = straight & ~lane_res[k].above;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= scan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && scan_i.valid) begin
      lane_res_q <= lane_res;
      straight_q <= straight;
    end
  end

  // Merge and output register.
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic signed [SPEED_W-1:0] left_speed_q;
  logic signed [SPEED_W-1:0] right_speed_q;
  logic                      went_straight_q;

  wfs_merge u_merge (
    .lanes_i       (lane_res_q),
    .straight_i    (straight_q),
    .bias_speed_i  (bias_speed_q),
    .max_speed_i   (max_speed_q),
    .left_speed_o  (left_speed),
    .right_speed_o (right_speed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      left_speed_q    <= left_speed;
      right_speed_q   <= right_speed;
      went_straight_q <= straight_q;
    end
  end

  assign speed_o.valid         = out_valid_q;
  assign speed_o.left_speed    = left_speed_q;
  assign speed_o.right_speed   = right_speed_q;
  assign speed_o.went_straight = went_straight_q;

endmodule

// ===== hw/rtl/wfs_checker.sv =====
// ----------------------------------------------------------------------------
// wfs_checker
// Port-level checks on the wall-follow steering unit, bound to the top level.
// ----------------------------------------------------------------------------
module wfs_checker
  import wfs_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [SPEED_W-1:0] left_speed,
  input logic signed [SPEED_W-1:0] right_speed,
  input logic                      went_straight
);

  localparam logic signed [SPEED_W-1:0] SPEED_MOST_NEG = {1'b1, {(SPEED_W-1){1'b0}}};

  // A stalled word must hold until it is taken.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(left_speed)
      && $stable(right_speed) && $stable(went_straight))
    else $error("output word changed while stalled");

  // Driving straight gives both wheels the same saturated bias.
  a_straight_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && went_straight |-> left_speed == right_speed)
    else $error("straight result with unequal wheel speeds");

  a_straight_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && went_straight |-> !left_speed[SPEED_W-1])
    else $error("straight result with negative speed");

  // Saturation is symmetric, so the most negative code never appears.
  a_no_most_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> left_speed != SPEED_MOST_NEG && right_speed != SPEED_MOST_NEG)
    else $error("speed outside the saturation range");

endmodule

bind wall_follow_steering_unit wfs_checker u_wfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (speed_o.valid),
  .out_ready     (speed_o.ready),
  .left_speed    (speed_o.left_speed),
  .right_speed   (speed_o.right_speed),
  .went_straight (speed_o.went_straight)
);
